[rtl/servo_write_packet_framer_defines.svh]
// assertion macros for the servo write packet framer checker
`ifndef SERVO_WRITE_PACKET_FRAMER_DEFINES_SVH
`define SERVO_WRITE_PACKET_FRAMER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SWPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SWPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/swpf_pkg.sv]
// shared types, constants and the crc function of the servo write packet framer
package swpf_pkg;

    // command kinds
    localparam logic [2:0] KIND_POS        = 3'd0;
    localparam logic [2:0] KIND_ANGLE_SPD  = 3'd1;
    localparam logic [2:0] KIND_WHEEL      = 3'd2;
    localparam logic [2:0] KIND_SET_ID     = 3'd3;
    localparam logic [2:0] KIND_SET_MODE   = 3'd4;
    localparam logic [2:0] KIND_RET_DELAY  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_CRC_INIT    = 3'd0;
    localparam logic [2:0] REG_POS_ADDR    = 3'd1;
    localparam logic [2:0] REG_SPEED_ADDR  = 3'd2;
    localparam logic [2:0] REG_ID_ADDR     = 3'd3;
    localparam logic [2:0] REG_MODE_ADDR   = 3'd4;
    localparam logic [2:0] REG_DELAY_ADDR  = 3'd5;

    // configuration reset values
    localparam logic [15:0] RST_CRC_INIT   = 16'd0;
    localparam logic [15:0] RST_POS_ADDR   = 16'd30;
    localparam logic [15:0] RST_SPEED_ADDR = 16'd32;
    localparam logic [15:0] RST_ID_ADDR    = 16'd3;
    localparam logic [15:0] RST_MODE_ADDR  = 16'd11;
    localparam logic [15:0] RST_DELAY_ADDR = 16'd5;

    // packet constants
    localparam logic [7:0]  HDR_SYNC       = 8'hFF;
    localparam logic [7:0]  HDR_MARK       = 8'hFD;
    localparam logic [7:0]  HDR_RSVD       = 8'h00;
    localparam logic [7:0]  INSTR_WRITE    = 8'h03;
    localparam logic [15:0] CRC_POLY       = 16'h8005;
    localparam logic [2:0]  LEN_OVERHEAD   = 3'd5;

    // byte positions within a packet
    localparam logic [4:0] IDX_SYNC0   = 5'd0;
    localparam logic [4:0] IDX_SYNC1   = 5'd1;
    localparam logic [4:0] IDX_MARK    = 5'd2;
    localparam logic [4:0] IDX_RSVD    = 5'd3;
    localparam logic [4:0] IDX_ID      = 5'd4;
    localparam logic [4:0] IDX_LEN_LO  = 5'd5;
    localparam logic [4:0] IDX_LEN_HI  = 5'd6;
    localparam logic [4:0] IDX_INSTR   = 5'd7;
    localparam logic [4:0] IDX_ADDR_LO = 5'd8;
    localparam logic [4:0] IDX_ADDR_HI = 5'd9;
    localparam logic [4:0] IDX_PARAM   = 5'd10;

    // angle to position: floor(a*256/75) by reciprocal, exact for a <= 300
    localparam logic [8:0]  ANGLE_MAX   = 9'd300;
    localparam logic [17:0] ANGLE_MUL   = 18'd223698;
    localparam int          ANGLE_SHIFT = 24;
    localparam int          PROD_W      = 35;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    // packet descriptor handed from front to back
    typedef struct packed {
        logic [7:0]       id;
        logic [15:0]      addr;
        logic [2:0]       np;
        logic [3:0][7:0]  params;
    } desc_t;

    // control table addresses used by the front
    typedef struct packed {
        logic [15:0] pos_addr;
        logic [15:0] speed_addr;
        logic [15:0] id_addr;
        logic [15:0] mode_addr;
        logic [15:0] delay_addr;
    } addr_cfg_t;

    // crc-16 0x8005, msb first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/swpf_queue.sv]
// two-entry descriptor queue between the front and the back
module swpf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  swpf_pkg::desc_t push_data,
    output logic           push_ready,
    input  logic           pop,
    output logic           head_valid,
    output swpf_pkg::desc_t head_data
);
    import swpf_pkg::*;

    desc_t          mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    // handshake and pointers
    assign push_ready = (count_reg != QAW'(0) + (QAW+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/swpf_front.sv]
// front: accepts commands, converts angles and builds packet descriptors
module swpf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          req_type,
    input  logic [7:0]          servo_id,
    input  logic [9:0]          position_value,
    input  logic [10:0]         speed_value,
    input  logic [7:0]          byte_value,
    input  swpf_pkg::addr_cfg_t addr_cfg,
    output logic                q_push,
    output swpf_pkg::desc_t     q_data,
    input  logic                q_ready
);
    import swpf_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic [2:0]        kind_reg;
    logic [7:0]        id_reg;
    logic [9:0]        pos_reg;
    logic [10:0]       spd_reg;
    logic [7:0]        bval_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              accept;
    logic              kind_ok;
    logic [8:0]        angle_sat;
    logic [16:0]       angle_scaled;
    logic [10:0]       quot;
    logic [9:0]        angle_pos;

    // input handshake; unused kinds are taken and dropped
    assign in_ready = !s1_valid_reg || q_ready;
    assign accept   = in_valid && in_ready;
    assign kind_ok  = (req_type <= KIND_RET_DELAY);
    assign q_push   = s1_valid_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = kind_ok;
        else if (q_ready)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // angle saturation and reciprocal multiply
    assign angle_sat    = (position_value > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : position_value[8:0];
    assign angle_scaled = {angle_sat, 8'h00};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req_type;
            id_reg   <= servo_id;
            pos_reg  <= position_value;
            spd_reg  <= speed_value;
            bval_reg <= byte_value;
            prod_reg <= PROD_W'(angle_scaled) * PROD_W'(ANGLE_MUL);
        end
    end

    // position from angle, minus one if nonzero
    assign quot      = prod_reg[ANGLE_SHIFT +: 11];
    assign angle_pos = (quot == '0) ? 10'd0 : 10'(quot - 11'd1);

    // descriptor per kind
    always_comb
    begin
        q_data.id     = id_reg;
        q_data.addr   = addr_cfg.pos_addr;
        q_data.np     = 3'd2;
        q_data.params = '0;
        unique case (kind_reg)
            KIND_POS:
            begin
                q_data.params[0] = pos_reg[7:0];
                q_data.params[1] = {6'd0, pos_reg[9:8]};
            end
            KIND_ANGLE_SPD:
            begin
                q_data.np        = 3'd4;
                q_data.params[0] = angle_pos[7:0];
                q_data.params[1] = {6'd0, angle_pos[9:8]};
                q_data.params[2] = spd_reg[7:0];
                q_data.params[3] = {5'd0, spd_reg[10:8]};
            end
            KIND_WHEEL:
            begin
                q_data.addr      = addr_cfg.speed_addr;
                q_data.params[0] = spd_reg[7:0];
                q_data.params[1] = {5'd0, spd_reg[10:8]};
            end
            KIND_SET_ID:
            begin
                q_data.addr      = addr_cfg.id_addr;
                q_data.np        = 3'd1;
                q_data.params[0] = bval_reg;
            end
            KIND_SET_MODE:
            begin
                q_data.addr      = addr_cfg.mode_addr;
                q_data.np        = 3'd1;
                q_data.params[0] = bval_reg;
            end
            KIND_RET_DELAY:
            begin
                q_data.addr      = addr_cfg.delay_addr;
                q_data.np        = 3'd1;
                q_data.params[0] = bval_reg;
            end
            default:
            begin
                q_data.np = 3'd1;
            end
        endcase
    end

endmodule

[rtl/swpf_back.sv]
// back: byte sequencer with running crc and output register
module swpf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  swpf_pkg::desc_t q_data,
    output logic            q_pop,
    input  logic [15:0]     crc_init,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      tx_byte,
    output logic            last_byte
);
    import swpf_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [4:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  tx_byte_reg;
    logic        last_byte_reg;
    logic        load;
    logic [4:0]  crc_lo_idx;
    logic [4:0]  last_idx;
    logic        at_last;
    logic [15:0] crc_cur;
    logic [4:0]  param_off;
    logic [7:0]  byte_sel;
    logic [7:0]  len_lo;

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign last_byte = last_byte_reg;

    // load a byte when the output register is free or being taken
    assign load       = q_valid && (!out_valid_reg || out_ready);
    assign crc_lo_idx = IDX_PARAM + 5'(q_data.np);
    assign last_idx   = crc_lo_idx + 5'd1;
    assign at_last    = (idx_reg == last_idx);
    assign q_pop      = load && at_last;
    assign crc_cur    = (idx_reg == IDX_SYNC0) ? crc_init : crc_reg;
    assign param_off  = idx_reg - IDX_PARAM;
    assign len_lo     = 8'(q_data.np) + 8'(LEN_OVERHEAD);

    // byte select
    always_comb
    begin
        byte_sel = HDR_RSVD;
        if (idx_reg == crc_lo_idx)
            byte_sel = crc_cur[7:0];
        else if (at_last)
            byte_sel = crc_cur[15:8];
        else if (idx_reg >= IDX_PARAM)
            byte_sel = q_data.params[param_off[1:0]];
        else
        begin
            case (idx_reg)
                IDX_SYNC0:   byte_sel = HDR_SYNC;
                IDX_SYNC1:   byte_sel = HDR_SYNC;
                IDX_MARK:    byte_sel = HDR_MARK;
                IDX_RSVD:    byte_sel = HDR_RSVD;
                IDX_ID:      byte_sel = q_data.id;
                IDX_LEN_LO:  byte_sel = len_lo;
                IDX_LEN_HI:  byte_sel = 8'h00;
                IDX_INSTR:   byte_sel = INSTR_WRITE;
                IDX_ADDR_LO: byte_sel = q_data.addr[7:0];
                IDX_ADDR_HI: byte_sel = q_data.addr[15:8];
                default:     byte_sel = HDR_RSVD;
            endcase
        end
    end

    // sequencer state; the crc stops before its own two bytes
    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = at_last ? IDX_SYNC0 : idx_reg + 5'd1;
            if (idx_reg < crc_lo_idx)
                crc_next = crc_byte(crc_cur, byte_sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= IDX_SYNC0;
            crc_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tx_byte_reg   <= byte_sel;
            last_byte_reg <= at_last;
        end
    end

endmodule

[rtl/servo_write_packet_framer.sv]
// servo write packet framer: configuration registers, front, queue and back
// path: accepted command -> front register -> queue -> back output register
// throughput: one byte per cycle from the back sequencer unless out_ready stalls,
// 13 to 16 bytes per command; front and queue hold two commands behind it
// reset: clears all control state and returns the registers to their defaults
module servo_write_packet_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [7:0]  servo_id,
    input  logic [9:0]  position_value,
    input  logic [10:0] speed_value,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        last_byte,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import swpf_pkg::*;

    logic [15:0] crc_init_reg;
    addr_cfg_t   addr_cfg_reg;
    logic        q_push;
    desc_t       q_push_data;
    logic        q_ready;
    logic        q_pop;
    logic        q_valid;
    desc_t       q_head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_init_reg            <= RST_CRC_INIT;
            addr_cfg_reg.pos_addr   <= RST_POS_ADDR;
            addr_cfg_reg.speed_addr <= RST_SPEED_ADDR;
            addr_cfg_reg.id_addr    <= RST_ID_ADDR;
            addr_cfg_reg.mode_addr  <= RST_MODE_ADDR;
            addr_cfg_reg.delay_addr <= RST_DELAY_ADDR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CRC_INIT:   crc_init_reg            <= cfg_data;
                REG_POS_ADDR:   addr_cfg_reg.pos_addr   <= cfg_data;
                REG_SPEED_ADDR: addr_cfg_reg.speed_addr <= cfg_data;
                REG_ID_ADDR:    addr_cfg_reg.id_addr    <= cfg_data;
                REG_MODE_ADDR:  addr_cfg_reg.mode_addr  <= cfg_data;
                REG_DELAY_ADDR: addr_cfg_reg.delay_addr <= cfg_data;
                default:        ;
            endcase
        end
    end

    // command front
    swpf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .servo_id       (servo_id),
        .position_value (position_value),
        .speed_value    (speed_value),
        .byte_value     (byte_value),
        .addr_cfg       (addr_cfg_reg),
        .q_push         (q_push),
        .q_data         (q_push_data),
        .q_ready        (q_ready)
    );

    // descriptor queue
    swpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // byte sequencer
    swpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .crc_init  (crc_init_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte),
        .last_byte (last_byte)
    );

endmodule

[rtl/swpf_checker.sv]
// port-level checker for the servo write packet framer and its bind
`include "servo_write_packet_framer_defines.svh"

module swpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] tx_byte,
    input logic       last_byte
);
    import swpf_pkg::*;

    logic after_last_reg;
    logic out_acc;

    assign out_acc = out_valid && out_ready;

    // tracks whether the next byte starts a packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            after_last_reg <= 1'b1;
        else if (out_acc)
            after_last_reg <= last_byte;
    end

    // a stalled byte holds
    `SWPF_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(tx_byte) && $stable(last_byte), "stalled output byte changed")

    // every packet opens with a sync byte
    `SWPF_ASSERT_NOW(a_packet_sync, out_valid && after_last_reg, tx_byte == HDR_SYNC && !last_byte, "packet does not start with sync byte")

    // the last byte is never followed directly by another last byte
    `SWPF_ASSERT_NEXT(a_no_double_last, out_acc && last_byte, !(out_valid && last_byte), "two last bytes in a row")

endmodule

bind servo_write_packet_framer swpf_checker u_swpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tx_byte   (tx_byte),
    .last_byte (last_byte)
);
